// ===== hw/rtl/rcpt_pkg.sv =====
// Package of the relay channel pairing table: result kinds, header length and
// the configuration register indexes. It has no dependencies.
`default_nettype none
package rcpt_pkg;
    localparam int unsigned AddrW = 48;
    localparam int unsigned IdW = 64;
    localparam int unsigned TimeW = 32;
    localparam int unsigned PktW = 32;
    localparam int unsigned ByteW = 48;
    localparam int unsigned LenW = 16;
    localparam int unsigned KindW = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [KindW-1:0] KIND_FORWARD = 3'd0;
    localparam logic [KindW-1:0] KIND_OPENED = 3'd1;
    localparam logic [KindW-1:0] KIND_PAIRED = 3'd2;
    localparam logic [KindW-1:0] KIND_DROPPED = 3'd3;
    localparam logic [KindW-1:0] KIND_FULL = 3'd4;
    localparam logic [KindW-1:0] KIND_EXPIRED = 3'd5;
    localparam logic [KindW-1:0] KIND_TICK = 3'd6;

    localparam logic [CfgIdxW-1:0] REG_INACTIVE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CLEANUP = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAGIC = 2'd2;

    localparam logic [LenW-1:0] HEADER_BYTES = 16'd20;

    typedef struct packed {
        logic                action;
        logic [AddrW-1:0]    src_addr;
        logic [LenW-1:0]     pkt_len;
        logic [TimeW-1:0]    header_magic;
        logic [IdW-1:0]      id_hi;
        logic [IdW-1:0]      id_lo;
    } req_t;

    typedef struct packed {
        logic [KindW-1:0]    kind;
        logic [AddrW-1:0]    dest_addr;
        logic [IdW-1:0]      out_id_hi;
        logic [IdW-1:0]      out_id_lo;
        logic [PktW-1:0]     packets_relayed;
        logic [ByteW-1:0]    bytes_relayed;
        logic                last;
    } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rcpt_if.sv =====
// Valid/ready channel carrying one request or one result of the table.
// It does not depend on rcpt_pkg; the payload type is given as a parameter.
`default_nettype none
interface rcpt_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/relay_channel_pairing_table.sv =====
// Relay channel pairing table. All scans share one slot index, one slot a cycle, and a
// sweep pauses while an expired result waits. A packet scans for a forward hit, then
// checks its header and scans the ids (a handshake), then decides; an invalid sender is
// dropped at once. A tick sweeps only when due, waiting on output stalls. One request at
// a time; the next is taken at earliest the cycle after the last result is accepted.
// Reset (asynchronous, active low) clears the slot valid bits, time and sweep counters.
`default_nettype none
module relay_channel_pairing_table #(
    parameter int unsigned CHANNELS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    rcpt_if.sink                              req,
    rcpt_if.source                            rsp,
    input  wire logic                         cfg_we,
    input  wire logic [rcpt_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [rcpt_pkg::CfgDataW-1:0] cfg_data
);
    import rcpt_pkg::*;

    localparam int unsigned SW = $clog2(CHANNELS);
    localparam int unsigned CW = $clog2(CHANNELS + 1);
    localparam int unsigned MidW = AddrW + 2 * IdW + PktW + ByteW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FWD = 3'd1;
    localparam logic [2:0] ST_HDR = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;
    localparam logic [2:0] ST_EXP = 3'd6;

    logic [2:0] state_reg;
    logic [CW-1:0] idx_reg;
    req_t cur_reg;
    rsp_t out_reg;
    logic out_valid_reg;
    logic [TimeW-1:0] limit_reg, period_reg, magic_reg, now_reg, sweep_reg;
    logic [CHANNELS-1:0] used_reg, paired_reg;
    logic found_reg, free_ok_reg, sweeping_reg;
    logic [SW-1:0] found_idx_reg, free_idx_reg;

    logic [IdW-1:0]   id_hi_mem [CHANNELS];
    logic [IdW-1:0]   id_lo_mem [CHANNELS];
    logic [AddrW-1:0] first_mem [CHANNELS];
    logic [AddrW-1:0] second_mem [CHANNELS];
    logic [TimeW-1:0] seen_mem [CHANNELS];
    logic [PktW-1:0]  pkt_mem [CHANNELS];
    logic [ByteW-1:0] byte_mem [CHANNELS];

    logic [SW-1:0] slot;
    logic hit_fwd, hit_id, idle_exp, hdr_ok;
    logic [TimeW-1:0] now_plus;

    assign slot = idx_reg[SW-1:0];
    assign hit_fwd = used_reg[slot] && paired_reg[slot] &&
        (first_mem[slot] == cur_reg.src_addr || second_mem[slot] == cur_reg.src_addr);
    assign hit_id = used_reg[slot] && id_hi_mem[slot] == cur_reg.id_hi &&
        id_lo_mem[slot] == cur_reg.id_lo;
    assign idle_exp = used_reg[slot] && (now_reg - seen_mem[slot]) > limit_reg;
    assign hdr_ok = cur_reg.pkt_len >= HEADER_BYTES && cur_reg.header_magic == magic_reg &&
        (cur_reg.id_hi != '0 || cur_reg.id_lo != '0);
    assign now_plus = now_reg + 32'd1;

    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = out_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FWD && idx_reg < CW'(CHANNELS) && hit_fwd)
        begin
            seen_mem[slot] <= now_reg;
            pkt_mem[slot] <= pkt_mem[slot] + 32'd1;
            byte_mem[slot] <= byte_mem[slot] + ByteW'(cur_reg.pkt_len);
        end
        else if (state_reg == ST_DECIDE && !found_reg && free_ok_reg)
        begin
            id_hi_mem[free_idx_reg] <= cur_reg.id_hi;
            id_lo_mem[free_idx_reg] <= cur_reg.id_lo;
            first_mem[free_idx_reg] <= cur_reg.src_addr;
            second_mem[free_idx_reg] <= '0;
            seen_mem[free_idx_reg] <= now_reg;
            pkt_mem[free_idx_reg] <= '0;
            byte_mem[free_idx_reg] <= '0;
        end
        else if (state_reg == ST_DECIDE && found_reg &&
                 first_mem[found_idx_reg] != cur_reg.src_addr && !paired_reg[found_idx_reg])
        begin
            second_mem[found_idx_reg] <= cur_reg.src_addr;
            seen_mem[found_idx_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            cur_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
            limit_reg <= 32'd30000;
            period_reg <= 32'd1000;
            magic_reg <= '0;
            now_reg <= '0;
            sweep_reg <= '0;
            used_reg <= '0;
            paired_reg <= '0;
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            sweeping_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INACTIVE: limit_reg <= cfg_data;
                    REG_CLEANUP:  period_reg <= cfg_data;
                    REG_MAGIC:    magic_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && rsp.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        cur_reg <= req.data;
                        idx_reg <= '0;
                        found_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        if (req.data.action)
                        begin
                            out_reg <= '0;
                            now_reg <= now_plus;
                            sweeping_reg <= (now_plus - sweep_reg) < 32'h8000_0000;
                            state_reg <= ST_SWEEP;
                        end
                        else if (req.data.src_addr == '0)
                        begin
                            out_reg <= {KIND_DROPPED, MidW'(0), 1'b1};
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            out_reg <= '0;
                            state_reg <= ST_FWD;
                        end
                    end
                end
                ST_FWD:
                begin
                    if (idx_reg == CW'(CHANNELS))
                    begin
                        idx_reg <= '0;
                        state_reg <= ST_HDR;
                    end
                    else if (hit_fwd)
                    begin
                        out_reg.kind <= KIND_FORWARD;
                        out_reg.dest_addr <= (first_mem[slot] != cur_reg.src_addr) ?
                            first_mem[slot] : second_mem[slot];
                        out_reg.out_id_hi <= id_hi_mem[slot];
                        out_reg.out_id_lo <= id_lo_mem[slot];
                        out_reg.last <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                ST_HDR:
                begin
                    if (!hdr_ok)
                    begin
                        out_reg.kind <= KIND_DROPPED;
                        out_reg.last <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else if (idx_reg == CW'(CHANNELS))
                        state_reg <= ST_DECIDE;
                    else
                    begin
                        if (used_reg[slot])
                        begin
                            if (!found_reg && hit_id)
                            begin
                                found_reg <= 1'b1;
                                found_idx_reg <= slot;
                            end
                        end
                        else if (!free_ok_reg)
                        begin
                            free_ok_reg <= 1'b1;
                            free_idx_reg <= slot;
                        end
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_DECIDE:
                begin
                    out_reg.last <= 1'b1;
                    state_reg <= ST_OUT;
                    if (!found_reg)
                    begin
                        out_reg.out_id_hi <= cur_reg.id_hi;
                        out_reg.out_id_lo <= cur_reg.id_lo;
                        if (free_ok_reg)
                        begin
                            used_reg[free_idx_reg] <= 1'b1;
                            paired_reg[free_idx_reg] <= 1'b0;
                            out_reg.kind <= KIND_OPENED;
                        end
                        else
                            out_reg.kind <= KIND_FULL;
                    end
                    else if (first_mem[found_idx_reg] != cur_reg.src_addr &&
                             !paired_reg[found_idx_reg])
                    begin
                        paired_reg[found_idx_reg] <= 1'b1;
                        out_reg.out_id_hi <= cur_reg.id_hi;
                        out_reg.out_id_lo <= cur_reg.id_lo;
                        out_reg.kind <= KIND_PAIRED;
                    end
                    else
                    begin
                        out_reg.kind <= KIND_DROPPED;
                        out_reg.out_id_hi <= '0;
                        out_reg.out_id_lo <= '0;
                    end
                end
                ST_SWEEP:
                begin
                    if (!sweeping_reg || idx_reg == CW'(CHANNELS))
                    begin
                        if (sweeping_reg)
                            sweep_reg <= now_reg + period_reg;
                        out_reg <= {KIND_TICK, MidW'(0), 1'b1};
                        state_reg <= ST_OUT;
                    end
                    else if (idle_exp)
                    begin
                        out_reg.kind <= KIND_EXPIRED;
                        out_reg.dest_addr <= '0;
                        out_reg.out_id_hi <= id_hi_mem[slot];
                        out_reg.out_id_lo <= id_lo_mem[slot];
                        out_reg.packets_relayed <= pkt_mem[slot];
                        out_reg.bytes_relayed <= byte_mem[slot];
                        out_reg.last <= 1'b0;
                        used_reg[slot] <= 1'b0;
                        paired_reg[slot] <= 1'b0;
                        out_valid_reg <= 1'b1;
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= ST_EXP;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                ST_EXP:
                begin
                    // Hold the sweep until the expired result has been taken.
                    if (!out_valid_reg || rsp.ready)
                        state_reg <= ST_SWEEP;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench of the relay channel pairing table: directed and random requests,
// checked result by result against an in-bench model of the session table.
// Depends on rcpt_pkg, rcpt_if and relay_channel_pairing_table.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rcpt_pkg::*;

    localparam int unsigned CHANNELS = 32;
    localparam int unsigned SETTLE = CHANNELS + 8;
    localparam longint unsigned CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    rcpt_if #(.payload_t(req_t)) req_ch ();
    rcpt_if #(.payload_t(rsp_t)) rsp_ch ();

    relay_channel_pairing_table #(.CHANNELS(CHANNELS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Model of the session table
    logic [TimeW-1:0] idle_limit;
    logic [TimeW-1:0] sweep_period;
    logic [TimeW-1:0] magic_word;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] next_sweep;
    logic             ch_used [CHANNELS];
    logic [IdW-1:0]   ch_hi [CHANNELS];
    logic [IdW-1:0]   ch_lo [CHANNELS];
    logic [AddrW-1:0] ch_first [CHANNELS];
    logic             ch_paired [CHANNELS];
    logic [AddrW-1:0] ch_second [CHANNELS];
    logic [TimeW-1:0] ch_seen [CHANNELS];
    logic [PktW-1:0]  ch_pkts [CHANNELS];
    logic [ByteW-1:0] ch_bytes [CHANNELS];

    rsp_t pending_results [$];
    int errors;
    int src_idle;
    int snk_idle;
    longint unsigned cycles;

    logic [AddrW-1:0] addr_pool [4];
    logic [IdW-1:0]   id_pool [6];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle);

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_results.size() == 0)
                report($sformatf("unexpected result kind %0d", got.kind));
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.dest_addr !== want.dest_addr)
                    report($sformatf("dest %h, want %h", got.dest_addr, want.dest_addr));
                if (got.out_id_hi !== want.out_id_hi)
                    report($sformatf("id_hi %h, want %h", got.out_id_hi, want.out_id_hi));
                if (got.out_id_lo !== want.out_id_lo)
                    report($sformatf("id_lo %h, want %h", got.out_id_lo, want.out_id_lo));
                if (got.packets_relayed !== want.packets_relayed)
                    report($sformatf("packets %h, want %h",
                                     got.packets_relayed, want.packets_relayed));
                if (got.bytes_relayed !== want.bytes_relayed)
                    report($sformatf("bytes %h, want %h",
                                     got.bytes_relayed, want.bytes_relayed));
                if (got.last !== want.last)
                    report($sformatf("last %b, want %b", got.last, want.last));
            end
        end
    end

    function automatic void table_clear();
        idle_limit = 32'd30000;
        sweep_period = 32'd1000;
        magic_word = '0;
        now_ms = '0;
        next_sweep = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_used[i] = 1'b0;
            ch_paired[i] = 1'b0;
        end
    endfunction

    function automatic void table_apply(input req_t r);
        rsp_t e;
        int found;
        int free_slot;
        e = '0;
        e.last = 1'b1;
        found = -1;
        free_slot = -1;
        if (r.action)
        begin
            now_ms = now_ms + 1;
            if (TimeW'(now_ms - next_sweep) < 32'h8000_0000)
            begin
                for (int i = 0; i < CHANNELS; i++)
                    if (ch_used[i] && TimeW'(now_ms - ch_seen[i]) > idle_limit)
                    begin
                        rsp_t x;
                        x = '0;
                        x.kind = KIND_EXPIRED;
                        x.out_id_hi = ch_hi[i];
                        x.out_id_lo = ch_lo[i];
                        x.packets_relayed = ch_pkts[i];
                        x.bytes_relayed = ch_bytes[i];
                        pending_results.push_back(x);
                        ch_used[i] = 1'b0;
                        ch_paired[i] = 1'b0;
                    end
                next_sweep = now_ms + sweep_period;
            end
            e.kind = KIND_TICK;
            pending_results.push_back(e);
            return;
        end
        e.kind = KIND_DROPPED;
        if (r.src_addr == '0)
        begin
            pending_results.push_back(e);
            return;
        end
        for (int i = 0; i < CHANNELS; i++)
            if (ch_used[i] && ch_paired[i] &&
                (ch_first[i] == r.src_addr || ch_second[i] == r.src_addr))
            begin
                e.kind = KIND_FORWARD;
                e.dest_addr = (ch_first[i] != r.src_addr) ? ch_first[i] : ch_second[i];
                e.out_id_hi = ch_hi[i];
                e.out_id_lo = ch_lo[i];
                ch_seen[i] = now_ms;
                ch_pkts[i] = ch_pkts[i] + 1;
                ch_bytes[i] = ch_bytes[i] + r.pkt_len;
                pending_results.push_back(e);
                return;
            end
        if (r.pkt_len < HEADER_BYTES || r.header_magic != magic_word ||
            (r.id_hi == '0 && r.id_lo == '0))
        begin
            pending_results.push_back(e);
            return;
        end
        for (int i = 0; i < CHANNELS; i++)
            if (ch_used[i])
            begin
                if (found < 0 && ch_hi[i] == r.id_hi && ch_lo[i] == r.id_lo)
                    found = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        if (found < 0)
        begin
            e.out_id_hi = r.id_hi;
            e.out_id_lo = r.id_lo;
            if (free_slot < 0)
                e.kind = KIND_FULL;
            else
            begin
                e.kind = KIND_OPENED;
                ch_used[free_slot] = 1'b1;
                ch_hi[free_slot] = r.id_hi;
                ch_lo[free_slot] = r.id_lo;
                ch_first[free_slot] = r.src_addr;
                ch_paired[free_slot] = 1'b0;
                ch_second[free_slot] = '0;
                ch_seen[free_slot] = now_ms;
                ch_pkts[free_slot] = '0;
                ch_bytes[free_slot] = '0;
            end
        end
        else if (ch_first[found] != r.src_addr && !ch_paired[found])
        begin
            e.kind = KIND_PAIRED;
            e.out_id_hi = r.id_hi;
            e.out_id_lo = r.id_lo;
            ch_second[found] = r.src_addr;
            ch_paired[found] = 1'b1;
            ch_seen[found] = now_ms;
        end
        pending_results.push_back(e);
    endfunction

    // A request that follows directly keeps valid high, so valid is
    // lowered in this task only when the sender chooses to idle.
    task automatic send_request(input req_t r);
        if ($urandom_range(99) < src_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        table_apply(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_INACTIVE)
            idle_limit = v;
        else if (idx == REG_CLEANUP)
            sweep_period = v;
        else if (idx == REG_MAGIC)
            magic_word = v;
    endtask

    function automatic req_t make_packet(input logic [AddrW-1:0] src,
                                         input logic [LenW-1:0] len,
                                         input logic [TimeW-1:0] mg,
                                         input logic [IdW-1:0] hi,
                                         input logic [IdW-1:0] lo);
        req_t r;
        r.action = 1'b0;
        r.src_addr = src;
        r.pkt_len = len;
        r.header_magic = mg;
        r.id_hi = hi;
        r.id_lo = lo;
        return r;
    endfunction

    function automatic req_t make_tick();
        req_t r;
        r = '0;
        r.action = 1'b1;
        return r;
    endfunction

    task automatic test_handshakes();
        logic [AddrW-1:0] a1;
        logic [AddrW-1:0] a2;
        a1 = '1;
        a2 = 48'h0a00_0001_1f90;
        write_reg(REG_MAGIC, 32'hFFFF_FFFF);
        write_reg(2'd3, 32'h1234_5678);
        send_request(make_packet('0, 16'd100, '1, 64'd1, 64'd1));
        send_request(make_packet(a1, 16'd19, '1, 64'd1, 64'd1));
        send_request(make_packet(a1, 16'd20, 32'hFFFF_FFFE, 64'd1, 64'd1));
        send_request(make_packet(a1, 16'd20, '1, '0, '0));
        send_request(make_packet(a1, 16'd20, '1, '1, '1));
        send_request(make_packet(a1, 16'd40, '1, '1, '1));
        send_request(make_packet(a2, 16'd20, '1, '1, '1));
        send_request(make_packet(a1, 16'hFFFF, '0, '0, '0));
        send_request(make_packet(a2, 16'd0, '0, '0, '0));
        send_request(make_packet(48'h1, 16'd64, '1, '1, '1));
        send_request(make_packet(48'h2, 16'd64, '1, '0, 64'd5));
        wait_drained();
    endtask

    // The table fills, then with a zero idle limit the first sweep
    // evicts every channel in one tick.
    task automatic test_full_and_evict();
        for (int k = 0; k < CHANNELS; k++)
            send_request(make_packet(48'h100 + k, 16'd20, '1, 64'd7, 64'(k)));
        send_request(make_packet(48'h300, 16'd20, '1, 64'd8, 64'd8));
        wait_drained();
        write_reg(REG_INACTIVE, '0);
        write_reg(REG_CLEANUP, '0);
        send_request(make_tick());
        send_request(make_tick());
        wait_drained();
        write_reg(REG_INACTIVE, '1);
        write_reg(REG_CLEANUP, '1);
        send_request(make_packet(48'h400, 16'd20, '1, 64'd9, 64'd9));
        send_request(make_tick());
        send_request(make_tick());
        wait_drained();
        write_reg(REG_MAGIC, '0);
        write_reg(REG_CLEANUP, 32'h8000_0000);
        send_request(make_tick());
        send_request(make_tick());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        req_t r;
        int pick;
        for (int k = 0; k < 4; k++)
            addr_pool[k] = AddrW'({$urandom, $urandom});
        for (int k = 0; k < 6; k++)
            id_pool[k] = {$urandom, $urandom};
        write_reg(REG_MAGIC, $urandom);
        write_reg(REG_INACTIVE, $urandom_range(40, 2));
        write_reg(REG_CLEANUP, $urandom_range(8, 0));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                r = make_tick();
            else if (pick < 85)
                r = make_packet(addr_pool[$urandom_range(3)],
                                ($urandom_range(9) == 0) ? 16'hFFFF
                                                         : LenW'($urandom_range(1500, 20)),
                                magic_word, id_pool[$urandom_range(5)],
                                id_pool[$urandom_range(5)]);
            else
            begin
                r = make_packet(AddrW'({$urandom, $urandom}), LenW'($urandom),
                                $urandom, {$urandom, $urandom}, {$urandom, $urandom});
                if ($urandom_range(3) == 0)
                    r.src_addr = addr_pool[$urandom_range(3)];
            end
            send_request(r);
        end
        wait_drained();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        src_idle = 21;
        snk_idle = 81;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        table_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_handshakes();
        test_full_and_evict();
        test_random_traffic(40);
        src_idle = 81;
        snk_idle = 21;
        test_random_traffic(40);
        src_idle = 0;
        snk_idle = 0;
        test_random_traffic(40);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
